FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files of the stack block.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true at an edge implies consequent at the same edge.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent true at an edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition that must hold at every edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   `ASSERT_IMPLIES(lbl, clk, rst, 1'b1, cond, msg)

`endif

FILE: rtl/stk_pkg.sv
// Package for the stack with remove-lowest: operation and status codes,
// controller states and the cell control struct. No dependencies.
package stk_pkg;

   localparam int DATA_W  = 32;
   localparam int COUNT_W = 5;

   // Operation codes carried in func
   typedef enum logic [1:0] {
      OP_PUSH       = 2'd0,
      OP_POP        = 2'd1,
      OP_PEEK       = 2'd2,
      OP_REMOVE_MIN = 2'd3
   } op_type;

   // Result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;

   // Data returned by remove-lowest on an empty stack
   localparam logic signed [DATA_W-1:0] EMPTY_MIN_DATA = -32'sd1;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PURGE
   } state_type;

   // What every cell does this cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_UP,
      CELL_DOWN
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type mode;
      logic          load;
   } stk_ctl_type;

endpackage

FILE: rtl/stk_if.sv
// Valid/ready channel interfaces for the stack requests and results.
// Depends on stk_pkg for payload widths.
interface stk_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         func;
   logic signed [stk_pkg::DATA_W-1:0]  push_value;

   modport source (output valid, func, push_value, input ready);
   modport sink   (input valid, func, push_value, output ready);
endinterface

interface stk_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [stk_pkg::DATA_W-1:0]  data;
   logic [1:0]                         status;
   logic                               is_empty;
   logic                               is_full;
   logic [stk_pkg::COUNT_W-1:0]        count;

   modport source (output valid, data, status, is_empty, is_full, count, input ready);
   modport sink   (input valid, data, status, is_empty, is_full, count, output ready);
endinterface

FILE: rtl/stk_cell.sv
// One storage cell of the stack chain: shifts towards the top or bottom,
// or loads the fed-back top word at its own index. Depends on stk_pkg.
module stk_cell #(
   parameter int IDX_W    = 4,
   parameter int CELL_IDX = 0
) (
   input  logic                               clock,
   input  stk_pkg::stk_ctl_type               ctl,
   input  logic [IDX_W-1:0]                   wr_idx,
   input  logic signed [stk_pkg::DATA_W-1:0]  above,
   input  logic signed [stk_pkg::DATA_W-1:0]  below,
   input  logic signed [stk_pkg::DATA_W-1:0]  feed,
   output logic signed [stk_pkg::DATA_W-1:0]  q
);

   logic signed [stk_pkg::DATA_W-1:0] word_ff;
   logic signed [stk_pkg::DATA_W-1:0] word_in;

   // neighbour selection, then the indexed load wins
   always_comb begin
      case (ctl.mode)
         stk_pkg::CELL_UP: begin
            word_in = below;
         end
         stk_pkg::CELL_DOWN: begin
            word_in = above;
         end
         default: begin
            word_in = word_ff;
         end
      endcase
      if (ctl.load && (wr_idx == IDX_W'(CELL_IDX))) begin
         word_in = feed;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign q = word_ff;

endmodule

FILE: rtl/stack_with_remove_min.sv
// Top level of the bounded stack with remove-lowest: controller and cell chain.
// Depends on stk_pkg, stk_if.sv, stk_cell and assert_macros.svh.
//
//  channel   | dir | transfer          | payload
//  ----------+-----+-------------------+-----------------------------------------
//  req_chan  | in  | valid & ready     | func, push_value
//  rsp_chan  | out | valid & ready     | data, status, is_empty, is_full, count
//
// Push, pop and peek results are registered at the accepting edge.
// Remove-lowest on N entries rotates the chain once through cell 0 to find the
// lowest word and once more to drop its copies, one cell a cycle.
// Reset clears the fill count and control only; cells above the count are never read.
// A new request is taken only when the controller is idle and the result register is
// empty or being emptied in the same cycle.
`include "assert_macros.svh"

module stack_with_remove_min #(
   parameter int DEPTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   stk_req_if.sink         req_chan,
   stk_rsp_if.source       rsp_chan
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int EXT_W = (CNT_W > stk_pkg::COUNT_W) ? CNT_W : stk_pkg::COUNT_W;

   // controller registers
   stk_pkg::state_type                 state_ff, state_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic [IDX_W-1:0]                   step_ff, step_in;
   logic [CNT_W-1:0]                   drop_ff, drop_in;
   logic signed [stk_pkg::DATA_W-1:0]  min_ff, min_in;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [stk_pkg::DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [1:0]                         rsp_status_ff, rsp_status_in;
   logic                               rsp_empty_ff, rsp_empty_in;
   logic                               rsp_full_ff, rsp_full_in;
   logic [stk_pkg::COUNT_W-1:0]        rsp_count_ff, rsp_count_in;

   // chain control
   stk_pkg::stk_ctl_type               cell_ctl;
   logic [IDX_W-1:0]                   wr_idx;
   logic signed [stk_pkg::DATA_W-1:0]  cell_q [DEPTH];
   logic signed [stk_pkg::DATA_W-1:0]  top_word;

   logic                               accept;
   logic                               load_rsp;
   logic                               keep;
   logic [IDX_W-1:0]                   last_step;
   logic signed [stk_pkg::DATA_W-1:0]  res_data;
   logic [1:0]                         res_status;
   logic [EXT_W-1:0]                   count_ext;

   assign top_word  = cell_q[0];
   assign accept    = req_chan.valid && req_chan.ready;
   assign last_step = IDX_W'(count_ff - CNT_W'(1));

   assign req_chan.ready = (state_ff == stk_pkg::ST_IDLE) &&
                           (!rsp_valid_ff || rsp_chan.ready);

   // next state, chain control and result
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      step_in         = step_ff;
      drop_in         = drop_ff;
      min_in          = min_ff;
      cell_ctl.mode   = stk_pkg::CELL_HOLD;
      cell_ctl.load   = 1'b0;
      wr_idx          = last_step;
      load_rsp        = 1'b0;
      keep            = 1'b1;
      res_data        = '0;
      res_status      = stk_pkg::ST_OK;

      case (state_ff)
         stk_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_chan.func)
                  stk_pkg::OP_PUSH: begin
                     load_rsp = 1'b1;
                     if (count_ff == CNT_W'(DEPTH)) begin
                        res_status = stk_pkg::ST_OVERFLOW;
                     end else begin
                        cell_ctl.mode = stk_pkg::CELL_DOWN;
                        count_in      = count_ff + CNT_W'(1);
                     end
                  end
                  stk_pkg::OP_POP: begin
                     load_rsp = 1'b1;
                     if (count_ff == '0) begin
                        res_status = stk_pkg::ST_EMPTY;
                     end else begin
                        cell_ctl.mode = stk_pkg::CELL_UP;
                        count_in      = count_ff - CNT_W'(1);
                        res_data      = top_word;
                     end
                  end
                  stk_pkg::OP_PEEK: begin
                     load_rsp = 1'b1;
                     if (count_ff == '0) begin
                        res_status = stk_pkg::ST_EMPTY;
                     end else begin
                        res_data = top_word;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        load_rsp   = 1'b1;
                        res_status = stk_pkg::ST_EMPTY;
                        res_data   = stk_pkg::EMPTY_MIN_DATA;
                     end else begin
                        state_in = stk_pkg::ST_SCAN;
                        step_in  = '0;
                        drop_in  = '0;
                     end
                  end
               endcase
            end
         end

         // first rotation: every word passes cell 0 and returns to the tail
         stk_pkg::ST_SCAN: begin
            cell_ctl.mode = stk_pkg::CELL_UP;
            cell_ctl.load = 1'b1;
            if ((step_ff == '0) || (top_word < min_ff)) begin
               min_in = top_word;
            end
            if (step_ff == last_step) begin
               state_in = stk_pkg::ST_PURGE;
               step_in  = '0;
            end else begin
               step_in = step_ff + IDX_W'(1);
            end
         end

         // second rotation: copies of the lowest word are not written back
         stk_pkg::ST_PURGE: begin
            keep          = (top_word != min_ff);
            cell_ctl.mode = stk_pkg::CELL_UP;
            cell_ctl.load = keep;
            wr_idx        = IDX_W'(count_ff - CNT_W'(1) - drop_ff);
            if (!keep) begin
               drop_in = drop_ff + CNT_W'(1);
            end
            if (step_ff == last_step) begin
               state_in = stk_pkg::ST_IDLE;
               count_in = count_ff - drop_in;
               load_rsp = 1'b1;
               res_data = min_ff;
            end else begin
               step_in = step_ff + IDX_W'(1);
            end
         end

         default: begin
            state_in = stk_pkg::ST_IDLE;
         end
      endcase
   end

   // result register load and drain
   assign count_ext = EXT_W'(count_in);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_count_in  = rsp_count_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = res_data;
         rsp_status_in = res_status;
         rsp_empty_in  = (count_in == '0);
         rsp_full_in   = (count_in == CNT_W'(DEPTH));
         rsp_count_in  = count_ext[stk_pkg::COUNT_W-1:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stk_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      drop_ff       <= drop_in;
      min_ff        <= min_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // cell chain, cell 0 holds the top of the stack
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [stk_pkg::DATA_W-1:0] above_w;
      logic signed [stk_pkg::DATA_W-1:0] below_w;

      if (i == 0) begin : g_first
         assign above_w = req_chan.push_value;
      end else begin : g_mid_above
         assign above_w = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign below_w = cell_q[i];
      end else begin : g_mid_below
         assign below_w = cell_q[i+1];
      end

      stk_cell #(
         .IDX_W    (IDX_W),
         .CELL_IDX (i)
      ) u_cell (
         .clock  (clock),
         .ctl    (cell_ctl),
         .wr_idx (wr_idx),
         .above  (above_w),
         .below  (below_w),
         .feed   (top_word),
         .q      (cell_q[i])
      );
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.data     = rsp_data_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.is_empty = rsp_empty_ff;
   assign rsp_chan.is_full  = rsp_full_ff;
   assign rsp_chan.count    = rsp_count_ff;

   // checks
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "fill count above depth")
   `ASSERT_IMPLIES(a_ready_idle, clock, reset, req_chan.ready, state_ff == stk_pkg::ST_IDLE, "request taken while busy")
   `ASSERT_IMPLIES(a_drop_bound, clock, reset, state_ff == stk_pkg::ST_PURGE, drop_ff <= count_ff, "more entries dropped than held")
   `ASSERT_NEXT(a_purge_result, clock, reset, (state_ff == stk_pkg::ST_PURGE) && (state_in == stk_pkg::ST_IDLE), rsp_valid_ff, "remove-lowest gave no result")
   `ASSERT_NEXT(a_push_count, clock, reset, accept && (req_chan.func == stk_pkg::OP_PUSH) && (count_ff != CNT_W'(DEPTH)), count_ff == $past(count_ff) + CNT_W'(1), "push did not grow the stack")

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for the bounded stack with remove-lowest: directed and random
// operations, random gaps on both channels, every result checked against a local model.
// Depends on stk_pkg, stk_if.sv and stack_with_remove_min.
`timescale 1ns / 1ps

module tb_top;

   localparam int STACK_DEPTH  = 16;
   localparam int RANDOM_OPS   = 1850;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      stk_pkg::op_type                   op;
      logic signed [stk_pkg::DATA_W-1:0] value;
   } stack_op_type;

   typedef struct {
      logic signed [stk_pkg::DATA_W-1:0] data;
      logic [1:0]                        status;
      logic                              is_empty;
      logic                              is_full;
      logic [stk_pkg::COUNT_W-1:0]       count;
   } stack_result_type;

   logic clock;
   logic reset;

   stk_req_if req_chan();
   stk_rsp_if rsp_chan();

   stack_with_remove_min #(
      .DEPTH (STACK_DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Clock, 12 ns period
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   stack_op_type     pending_ops[$];
   stack_result_type results_due[$];

   // Local copy of the stack contents
   logic signed [stk_pkg::DATA_W-1:0] model_cells [STACK_DEPTH];
   int                                model_fill;

   int   error_count;
   int   idle_cycles;
   logic req_xfer;
   logic rsp_xfer;
   int   req_gap;
   int   rsp_stall;
   logic req_quiet;
   logic rsp_quiet;

   // Apply one operation to the local stack and return the result it produces
   function automatic stack_result_type apply_stack_op(
      stk_pkg::op_type op, logic signed [stk_pkg::DATA_W-1:0] value);
      stack_result_type                  res;
      logic signed [stk_pkg::DATA_W-1:0] lowest;
      int                                kept;
      res.data   = '0;
      res.status = stk_pkg::ST_OK;
      case (op)
         stk_pkg::OP_PUSH: begin
            if (model_fill >= STACK_DEPTH) begin
               res.status = stk_pkg::ST_OVERFLOW;
            end else begin
               model_cells[model_fill] = value;
               model_fill++;
            end
         end
         stk_pkg::OP_POP: begin
            if (model_fill == 0) begin
               res.status = stk_pkg::ST_EMPTY;
            end else begin
               model_fill--;
               res.data = model_cells[model_fill];
            end
         end
         stk_pkg::OP_PEEK: begin
            if (model_fill == 0)
               res.status = stk_pkg::ST_EMPTY;
            else
               res.data = model_cells[model_fill-1];
         end
         default: begin
            if (model_fill == 0) begin
               res.status = stk_pkg::ST_EMPTY;
               res.data   = stk_pkg::EMPTY_MIN_DATA;
            end else begin
               // find the lowest word, then squeeze out every copy of it
               lowest = model_cells[0];
               for (int i = 1; i < model_fill; i++)
                  if (model_cells[i] < lowest)
                     lowest = model_cells[i];
               kept = 0;
               for (int i = 0; i < model_fill; i++)
                  if (model_cells[i] != lowest) begin
                     model_cells[kept] = model_cells[i];
                     kept++;
                  end
               model_fill = kept;
               res.data   = lowest;
            end
         end
      endcase
      res.is_empty = (model_fill == 0);
      res.is_full  = (model_fill >= STACK_DEPTH);
      res.count    = model_fill[stk_pkg::COUNT_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [stk_pkg::DATA_W-1:0] got,
                                  input logic [stk_pkg::DATA_W-1:0] want);
      $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
      error_count++;
   endtask

   // Occasionally switch between gappy and back-to-back behaviour
   function automatic int draw_wait(inout logic quiet);
      if ($urandom_range(0, 39) == 0)
         quiet = ~quiet;
      return quiet ? 0 : $urandom_range(0, 3);
   endfunction

   function automatic logic signed [stk_pkg::DATA_W-1:0] draw_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $signed($urandom_range(0, 6)) - 3;
         4: return 32'sh7fff_ffff;
         5: return 32'sh8000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_op(input stk_pkg::op_type op,
                           input logic signed [stk_pkg::DATA_W-1:0] value);
      stack_op_type item;
      item.op    = op;
      item.value = value;
      pending_ops.push_back(item);
   endtask

   // Request driver: presents the next pending item after a random gap
   always @(negedge clock) begin : drive_req
      stack_op_type next_op;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_xfer) begin
         if (req_gap > 0) begin
            req_gap--;
            req_chan.valid <= 1'b0;
         end else if (pending_ops.size() != 0) begin
            next_op = pending_ops.pop_front();
            req_chan.valid      <= 1'b1;
            req_chan.func       <= next_op.op;
            req_chan.push_value <= next_op.value;
            req_gap = draw_wait(req_quiet);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Result sink: stalls ready for a random number of cycles per result
   always @(negedge clock) begin : drive_rsp
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_xfer)
            rsp_stall = draw_wait(rsp_quiet);
         if (rsp_stall > 0) begin
            rsp_chan.ready <= 1'b0;
            if (rsp_chan.valid)
               rsp_stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Monitor: predict on each request transfer, check each result transfer
   always @(posedge clock) begin : monitor
      stack_result_type want;
      if (reset) begin
         req_xfer    <= 1'b0;
         rsp_xfer    <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_xfer <= req_chan.valid && req_chan.ready;
         rsp_xfer <= rsp_chan.valid && rsp_chan.ready;
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (results_due.size() == 0) begin
               report_mismatch("unexpected result", rsp_chan.data, '0);
            end else begin
               want = results_due.pop_front();
               if (rsp_chan.data !== want.data)
                  report_mismatch("data", rsp_chan.data, want.data);
               if (rsp_chan.status !== want.status)
                  report_mismatch("status", rsp_chan.status, want.status);
               if (rsp_chan.is_empty !== want.is_empty)
                  report_mismatch("is_empty", rsp_chan.is_empty, want.is_empty);
               if (rsp_chan.is_full !== want.is_full)
                  report_mismatch("is_full", rsp_chan.is_full, want.is_full);
               if (rsp_chan.count !== want.count)
                  report_mismatch("count", rsp_chan.count, want.count);
            end
         end
         if (req_chan.valid && req_chan.ready)
            results_due.push_back(apply_stack_op(stk_pkg::op_type'(req_chan.func),
                                                 req_chan.push_value));
         // watchdog on cycles without any transfer
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin
      int              made;
      int              seg_len;
      int              seg_kind;
      int              pick;
      stk_pkg::op_type op;

      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.func       = stk_pkg::OP_PUSH;
      req_chan.push_value = '0;
      rsp_chan.ready      = 1'b0;
      model_fill          = 0;
      error_count         = 0;
      req_gap             = 0;
      rsp_stall           = 0;
      req_quiet           = 1'b0;
      rsp_quiet           = 1'b0;

      // directed: empty stack, extremes, duplicates of the lowest word
      queue_op(stk_pkg::OP_POP, 0);
      queue_op(stk_pkg::OP_PEEK, 0);
      queue_op(stk_pkg::OP_REMOVE_MIN, 0);
      queue_op(stk_pkg::OP_PUSH, 32'sh7fff_ffff);
      queue_op(stk_pkg::OP_PUSH, 32'sh8000_0000);
      queue_op(stk_pkg::OP_PUSH, 0);
      queue_op(stk_pkg::OP_PUSH, -1);
      queue_op(stk_pkg::OP_PUSH, 5);
      queue_op(stk_pkg::OP_PUSH, -1);
      queue_op(stk_pkg::OP_PUSH, 32'sh8000_0000);
      queue_op(stk_pkg::OP_REMOVE_MIN, 0);
      queue_op(stk_pkg::OP_PEEK, 0);
      queue_op(stk_pkg::OP_POP, 0);
      queue_op(stk_pkg::OP_REMOVE_MIN, 0);
      queue_op(stk_pkg::OP_POP, 0);
      queue_op(stk_pkg::OP_POP, 0);
      queue_op(stk_pkg::OP_POP, 0);
      queue_op(stk_pkg::OP_POP, 0);
      queue_op(stk_pkg::OP_PUSH, 9);
      queue_op(stk_pkg::OP_PUSH, 9);
      queue_op(stk_pkg::OP_PUSH, 9);
      queue_op(stk_pkg::OP_REMOVE_MIN, 0);
      queue_op(stk_pkg::OP_PEEK, 0);

      // random segments that lean towards filling, draining or a plain mix
      made = 0;
      while (made < RANDOM_OPS) begin
         seg_len  = $urandom_range(10, 60);
         seg_kind = $urandom_range(0, 2);
         for (int k = 0; k < seg_len; k++) begin
            pick = $urandom_range(0, 99);
            case (seg_kind)
               0: op = (pick < 75) ? stk_pkg::OP_PUSH :
                       stk_pkg::op_type'($urandom_range(1, 3));
               1: op = (pick < 20) ? stk_pkg::OP_PUSH : (pick < 55) ? stk_pkg::OP_POP :
                       (pick < 70) ? stk_pkg::OP_PEEK : stk_pkg::OP_REMOVE_MIN;
               default: op = stk_pkg::op_type'($urandom_range(0, 3));
            endcase
            // ignored payload still gets random bits
            queue_op(op, (op == stk_pkg::OP_PUSH) ? draw_value() : $urandom);
            made++;
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || req_chan.valid)
         @(negedge clock);
      while (results_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
